>>> rtl/mmas_pkg.sv
// ----------------------------------------------------------------------------
// mmas_pkg
// Shared widths, reset values, register indexes and types for the mouse
// motion smoothing and acceleration block.
// ----------------------------------------------------------------------------
package mmas_pkg;

    localparam int MMAS_COUNT_BITS     = 16;
    localparam int MMAS_GAIN_FRAC_BITS = 4;

    localparam int FRAC_BITS     = 16;
    localparam int GAIN_BITS     = 8;
    localparam int THR_BITS      = 10;
    localparam int BTN_BITS      = 8;
    localparam int OUT_BITS      = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [GAIN_BITS-1:0] GAIN_RST   = 8'd32;
    localparam logic [THR_BITS-1:0]  THR_RST    = 10'd10;
    localparam logic                 SMOOTH_RST = 1'b0;
    localparam logic                 VDIS_RST   = 1'b1;
    localparam logic                 MLOOK_RST  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN,
        CFG_THR,
        CFG_SMOOTH,
        CFG_VDIS,
        CFG_MLOOK
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SUB,
        S_CHK,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain;
        logic [THR_BITS-1:0]  thr;
    } t_accel_cfg;

endpackage

>>> rtl/mmas_in_if.sv
// ----------------------------------------------------------------------------
// mmas_in_if
// Motion input channel: per-tick counts, tick fraction and button mask.
// ----------------------------------------------------------------------------
interface mmas_in_if #(
    parameter int COUNT_BITS = mmas_pkg::MMAS_COUNT_BITS
);
    import mmas_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COUNT_BITS-1:0] delta_x;
    logic signed [COUNT_BITS-1:0] delta_y;
    logic [FRAC_BITS-1:0]         tick_fraction;
    logic [BTN_BITS-1:0]          button_mask;

    modport source (
        output valid, delta_x, delta_y, tick_fraction, button_mask,
        input  ready
    );

    modport sink (
        input  valid, delta_x, delta_y, tick_fraction, button_mask,
        output ready
    );

endinterface

>>> rtl/mmas_out_if.sv
// ----------------------------------------------------------------------------
// mmas_out_if
// Motion result channel: buttons and saturated accelerated motion.
// ----------------------------------------------------------------------------
interface mmas_out_if;
    import mmas_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [BTN_BITS-1:0]        buttons;
    logic signed [OUT_BITS-1:0] move_x;
    logic signed [OUT_BITS-1:0] move_y;

    modport source (
        output valid, buttons, move_x, move_y,
        input  ready
    );

    modport sink (
        input  valid, buttons, move_x, move_y,
        output ready
    );

endinterface

>>> rtl/mmas_div.sv
// ----------------------------------------------------------------------------
// mmas_div
// Bit-serial restoring divider for the smoothing factor
// f = floor(frac * 2^16 / (2^16 + frac)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmas_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mmas_pkg::FRAC_BITS-1:0] i_frac,
    output logic                           o_done,
    output logic [mmas_pkg::FRAC_BITS-1:0] o_quot
);
    import mmas_pkg::*;

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_done;
    logic [FRAC_BITS:0]   r_rem;
    logic [FRAC_BITS:0]   r_div;
    logic [FRAC_BITS-1:0] r_quot;

    logic [FRAC_BITS+2:0] w_trial;
    logic                 w_qbit;

    // Remainder stays below the divisor, so the doubled value fits one bit more.
    assign w_trial = {1'b0, r_rem, 1'b0} - {2'b00, r_div};
    assign w_qbit  = ~w_trial[FRAC_BITS+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_BITS'(FRAC_BITS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_BITS'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Dividend is frac followed by sixteen zero bits; frac < divisor, so the
    // upper half gives a zero quotient and becomes the starting remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_frac};
            r_div  <= {1'b1, i_frac};
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_qbit ? w_trial[FRAC_BITS:0] : {r_rem[FRAC_BITS-1:0], 1'b0};
            r_quot <= {r_quot[FRAC_BITS-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/mmas_accel.sv
// ----------------------------------------------------------------------------
// mmas_accel
// Threshold acceleration of one axis: magnitude above the threshold is scaled
// by the gain through a bit-serial multiplier, then sign restored and clamped.
// ----------------------------------------------------------------------------
module mmas_accel #(
    parameter int COUNT_BITS     = mmas_pkg::MMAS_COUNT_BITS,
    parameter int GAIN_FRAC_BITS = mmas_pkg::MMAS_GAIN_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [COUNT_BITS+2:0]        i_val,
    input  logic                                i_inv,
    input  mmas_pkg::t_accel_cfg                i_cfg,
    output logic                                o_done,
    output logic signed [mmas_pkg::OUT_BITS-1:0] o_move
);
    import mmas_pkg::*;

    localparam int V_BITS   = COUNT_BITS + 3;
    localparam int P_BITS   = V_BITS + GAIN_BITS;
    localparam int M_BITS   = (P_BITS >= OUT_BITS) ? P_BITS + 1 : OUT_BITS + 1;
    localparam int CNT_BITS = $clog2(GAIN_BITS + 2);
    localparam logic [CNT_BITS-1:0] CNT_FIN = CNT_BITS'(GAIN_BITS + 1);

    logic                       r_busy;
    logic [CNT_BITS-1:0]        r_cnt;
    logic                       r_done;
    logic [V_BITS-1:0]          r_mag;
    logic                       r_neg;
    logic [GAIN_BITS-1:0]       r_g;
    logic [THR_BITS-1:0]        r_thr;
    logic                       r_above;
    logic [V_BITS-1:0]          r_d;
    logic [P_BITS-1:0]          r_acc;
    logic signed [OUT_BITS-1:0] r_res;

    logic [V_BITS-1:0]   w_abs;
    logic [V_BITS-1:0]   w_thr_ext;
    logic [P_BITS-1:0]   w_addend;
    logic [M_BITS-1:0]   w_scaled;
    logic [M_BITS-1:0]   w_mag;
    logic [M_BITS-1:0]   w_lim;
    logic [M_BITS-1:0]   w_sat;
    logic [OUT_BITS-1:0] w_low;
    logic [OUT_BITS-1:0] w_res;

    assign w_abs     = i_val[V_BITS-1] ? V_BITS'(-i_val) : V_BITS'(i_val);
    assign w_thr_ext = V_BITS'(r_thr);
    assign w_addend  = r_g[GAIN_BITS-1] ? P_BITS'(r_d) : '0;

    assign w_scaled = M_BITS'(r_acc >> GAIN_FRAC_BITS) + M_BITS'(r_thr);
    assign w_mag    = r_above ? w_scaled : M_BITS'(r_mag);
    // Negative side reaches one step further than the positive side.
    assign w_lim    = r_neg ? (M_BITS'(1) << (OUT_BITS - 1))
                            : ((M_BITS'(1) << (OUT_BITS - 1)) - M_BITS'(1));
    assign w_sat    = (w_mag > w_lim) ? w_lim : w_mag;
    assign w_low    = w_sat[OUT_BITS-1:0];
    assign w_res    = r_neg ? -w_low : w_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_done <= (r_cnt == CNT_FIN);
            if (r_cnt == CNT_FIN) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= w_abs;
            r_neg <= i_val[V_BITS-1] ^ i_inv;
            r_g   <= i_cfg.gain;
            r_thr <= i_cfg.thr;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_above <= (r_mag > w_thr_ext);
                r_d     <= r_mag - w_thr_ext;
                r_acc   <= '0;
            end else if (r_cnt == CNT_FIN) begin
                r_res <= w_res;
            end else begin
                // MSB first: double and add the gain digit.
                r_acc <= (r_acc << 1) + w_addend;
                r_g   <= {r_g[GAIN_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_move = r_res;

endmodule

>>> rtl/mouse_motion_accel_smooth.sv
// ----------------------------------------------------------------------------
// mouse_motion_accel_smooth
// Smoothing off: each transaction is checked and, if it moves, accelerated and
// registered at the output; a transaction with no motion gives no result.
// Smoothing on: the 16-step factor divider and the 16-step serial carry
// multiplier run first, then the gain multiplier. No new transaction is taken
// until the last is through. A stalled result holds the next transaction back.
// Synchronous reset clears control, carries, configuration and output valid.
// ----------------------------------------------------------------------------
module mouse_motion_accel_smooth #(
    parameter int COUNT_BITS     = mmas_pkg::MMAS_COUNT_BITS,
    parameter int GAIN_FRAC_BITS = mmas_pkg::MMAS_GAIN_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mmas_in_if.sink                            i_mot,
    mmas_out_if.source                         o_mot,
    input  logic                               i_cfg_we,
    input  logic [mmas_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mmas_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import mmas_pkg::*;

    localparam int V_BITS    = COUNT_BITS + 3;
    localparam int V1_BITS   = V_BITS + 1;
    localparam int C_BITS    = COUNT_BITS + 2;
    localparam int MCNT_BITS = $clog2(FRAC_BITS);

    t_state r_state;
    t_state n_state;

    logic [GAIN_BITS-1:0] r_gain;
    logic [THR_BITS-1:0]  r_thr;
    logic                 r_smooth;
    logic                 r_vdis;
    logic                 r_mlook;

    logic signed [C_BITS-1:0] r_carry_x;
    logic signed [C_BITS-1:0] r_carry_y;
    logic signed [V_BITS-1:0] r_x;
    logic signed [V_BITS-1:0] r_y;
    logic [BTN_BITS-1:0]      r_btn;
    logic [FRAC_BITS-1:0]     r_fsh;
    logic [MCNT_BITS-1:0]     r_mcnt;
    logic signed [V_BITS-1:0] r_ax;
    logic signed [V_BITS-1:0] r_ay;

    logic                       r_ov;
    logic [BTN_BITS-1:0]        r_obtn;
    logic signed [OUT_BITS-1:0] r_omx;
    logic signed [OUT_BITS-1:0] r_omy;

    logic w_ready;
    logic w_take;
    logic w_div_start;
    logic w_mul_load;
    logic w_mul_step;
    logic w_sub;
    logic w_acc_start;
    logic w_out_load;
    logic w_zero;

    logic                       w_div_done;
    logic [FRAC_BITS-1:0]       w_quot;
    logic                       w_ax_done;
    logic                       w_ay_done;
    logic signed [OUT_BITS-1:0] w_ax_move;
    logic signed [OUT_BITS-1:0] w_ay_move;
    t_accel_cfg                 w_acfg;

    logic signed [V_BITS-1:0]  w_sx;
    logic signed [V_BITS-1:0]  w_sy;
    logic signed [V1_BITS-1:0] w_addx;
    logic signed [V1_BITS-1:0] w_addy;
    logic signed [V1_BITS-1:0] w_sumx;
    logic signed [V1_BITS-1:0] w_sumy;

    assign w_zero = (r_x == '0) && (r_y == '0);

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_mot.valid) begin
                    n_state = r_smooth ? S_DIV : S_CHK;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_mcnt == MCNT_BITS'(FRAC_BITS - 1)) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: n_state = S_CHK;
            S_CHK: n_state = w_zero ? S_IDLE : S_ACC;
            S_ACC: begin
                if (w_ax_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || o_mot.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready     = (r_state == S_IDLE);
        w_take      = w_ready && i_mot.valid;
        w_div_start = w_take && r_smooth;
        w_mul_load  = (r_state == S_DIV) && w_div_done;
        w_mul_step  = (r_state == S_MUL);
        w_sub       = (r_state == S_SUB);
        w_acc_start = (r_state == S_CHK) && !w_zero;
        w_out_load  = (r_state == S_OUT) && (!r_ov || o_mot.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_thr    <= THR_RST;
            r_smooth <= SMOOTH_RST;
            r_vdis   <= VDIS_RST;
            r_mlook  <= MLOOK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_THR:    r_thr    <= i_cfg_data[THR_BITS-1:0];
                CFG_SMOOTH: r_smooth <= i_cfg_data[0];
                CFG_VDIS:   r_vdis   <= i_cfg_data[0];
                CFG_MLOOK:  r_mlook  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- smoothing datapath ----------------
    assign w_sx = V_BITS'(i_mot.delta_x) + (r_smooth ? V_BITS'(r_carry_x) : V_BITS'(0));
    assign w_sy = V_BITS'(i_mot.delta_y) + (r_smooth ? V_BITS'(r_carry_y) : V_BITS'(0));

    // LSB-first shift-add; dropping the low bit each step keeps floor of the
    // product scaled down by 2^16.
    assign w_addx = r_fsh[0] ? V1_BITS'(r_x) : V1_BITS'(0);
    assign w_addy = r_fsh[0] ? V1_BITS'(r_y) : V1_BITS'(0);
    assign w_sumx = V1_BITS'(r_ax) + w_addx;
    assign w_sumy = V1_BITS'(r_ay) + w_addy;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x   <= w_sx;
            r_y   <= w_sy;
            r_btn <= i_mot.button_mask;
        end else if (w_sub) begin
            r_x <= r_x - r_ax;
            r_y <= r_y - r_ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_load) begin
            r_fsh <= w_quot;
            r_ax  <= '0;
            r_ay  <= '0;
        end else if (w_mul_step) begin
            r_fsh <= {1'b0, r_fsh[FRAC_BITS-1:1]};
            r_ax  <= w_sumx[V1_BITS-1:1];
            r_ay  <= w_sumy[V1_BITS-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt    <= '0;
            r_carry_x <= '0;
            r_carry_y <= '0;
        end else begin
            if (w_mul_load) begin
                r_mcnt <= '0;
            end else if (w_mul_step) begin
                r_mcnt <= r_mcnt + 1'b1;
            end
            if (w_sub) begin
                r_carry_x <= r_ax[C_BITS-1:0];
                r_carry_y <= r_ay[C_BITS-1:0];
            end
        end
    end

    mmas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_frac  (i_mot.tick_fraction),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---------------- acceleration ----------------
    assign w_acfg = '{gain: r_gain, thr: r_thr};

    mmas_accel #(
        .COUNT_BITS     (COUNT_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_accel_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc_start),
        .i_val   (r_x),
        .i_inv   (1'b0),
        .i_cfg   (w_acfg),
        .o_done  (w_ax_done),
        .o_move  (w_ax_move)
    );

    // Vertical motion leaves negated.
    mmas_accel #(
        .COUNT_BITS     (COUNT_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_accel_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc_start),
        .i_val   (r_y),
        .i_inv   (1'b1),
        .i_cfg   (w_acfg),
        .o_done  (w_ay_done),
        .o_move  (w_ay_move)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= 1'b1;
        end else if (o_mot.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_obtn <= r_btn;
            r_omx  <= w_ax_move;
            r_omy  <= (r_vdis && !r_mlook) ? '0 : w_ay_move;
        end
    end

    assign i_mot.ready   = w_ready;
    assign o_mot.valid   = r_ov;
    assign o_mot.buttons = r_obtn;
    assign o_mot.move_x  = r_omx;
    assign o_mot.move_y  = r_omy;

    // ---------------- assertions ----------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_accel_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ax_done == w_ay_done)
        else $error("axis accelerators out of step");

    a_accel_done_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ax_done |-> (r_state == S_ACC))
        else $error("accelerator finished outside the acceleration phase");

    a_carry_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SUB) |=> ($stable(r_carry_x) && $stable(r_carry_y)))
        else $error("carry changed outside the update step");

endmodule
